/* rtl/mtt_pkg.sv */
`timescale 1ns / 1ps

package mtt_pkg;

  localparam int unsigned ID_W        = 31;
  localparam int unsigned NOW_W       = 48;
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [ID_W-1:0] ID_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_SET_ONESHOT  = 2'd1,
    OP_SET_PERIODIC = 2'd2,
    OP_CLEAR        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_FULL     = 2'd2
  } kind_e;

  typedef struct packed {
    op_e              operation;
    logic [NOW_W-1:0] now_ms;
    logic [ID_W-1:0]  delay_ms;
    logic [ID_W-1:0]  timer_id;
  } in_item_t;

  typedef struct packed {
    kind_e           result_kind;
    logic [ID_W-1:0] result_id;
    logic            last_of_run;
  } out_item_t;

endpackage

/* rtl/multi_timer_table.sv */
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  in_item_i  (operation, now_ms, delay_ms, timer_id)
// out      out_valid_o/out_stall_i out_item_o (result_kind, result_id, last_of_run)
//
// Set: result goes straight to the output register.
// Clear: walks the used slots in order, stopping at the first id match.
// Tick: walks every used slot, then flushes the last fired item; one slot per cycle,
//   bound by the single read port of the slot memory; a full output can pause it.
// Reset clears the fill count and sets the id counter to one at once; no clearing pass.
// Output stall holds the input and pauses a tick whenever an item meets a full output register.
module multi_timer_table
  import mtt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned N_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic                 active;
    logic [ID_W-1:0]      ident;
    logic [TIME_BITS-1:0] due;
    logic [ID_W-1:0]      period;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                    input logic [ID_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS + 1)'(d);
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [ID_W-1:0]      next_id_q, next_id_d;
  logic                 is_clear_q, is_clear_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [ID_W-1:0]      tid_q, tid_d;
  logic [CNT_W-1:0]     proc_q, proc_d;
  logic [CNT_W-1:0]     w_q, w_d;
  logic [N_W-1:0]       n_q, n_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]      pend_id_q, pend_id_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [ENT_W-1:0]     mem_rdata;

  entry_t               ent;
  entry_t               wr_ent;
  logic [TIME_BITS-1:0] now_in;
  logic                 out_free;
  logic                 in_acc;
  logic                 fire;
  logic                 keep;
  logic                 more;
  logic                 adv;
  logic [CNT_W-1:0]     proc_inc;
  logic [CNT_W-1:0]     w_inc;

  mtt_mem #(
    .DEPTH  (TIMER_SLOTS),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign ent      = entry_t'(mem_rdata);
  assign now_in   = TIME_BITS'(in_item_i.now_ms);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;

  assign fire = !is_clear_q && ent.active && (now_q >= ent.due) &&
                (n_q < N_W'(MAX_RESULTS));
  assign keep = ent.active && !(fire && (ent.period == '0));
  assign adv  = !(fire && pend_valid_q && !out_free);
  assign proc_inc = proc_q + CNT_W'(1);
  assign w_inc    = w_q + CNT_W'(1);
  assign more = (({1'b0, proc_q} + (CNT_W + 1)'(1)) < {1'b0, used_q});

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    next_id_d    = next_id_q;
    is_clear_d   = is_clear_q;
    now_d        = now_q;
    tid_d        = tid_q;
    proc_d       = proc_q;
    w_d          = w_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    wr_ent       = ent;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item_i.operation) inside
            OP_SET_ONESHOT, OP_SET_PERIODIC: begin
              out_valid_d = 1'b1;
              if (used_q >= CNT_W'(TIMER_SLOTS)) begin
                out_d = '{result_kind: KIND_FULL, result_id: '0, last_of_run: 1'b1};
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = used_q[IDX_W-1:0];
                wr_ent.active = 1'b1;
                wr_ent.ident  = next_id_q;
                wr_ent.due    = sat_add(now_in, in_item_i.delay_ms);
                wr_ent.period = (in_item_i.operation == OP_SET_PERIODIC) ?
                                in_item_i.delay_ms : '0;
                used_d        = used_q + CNT_W'(1);
                out_d = '{result_kind: KIND_ASSIGNED, result_id: next_id_q,
                          last_of_run: 1'b1};
                next_id_d = (next_id_q == ID_MAX) ? ID_W'(1) : next_id_q + ID_W'(1);
              end
            end
            OP_TICK, OP_CLEAR: begin
              is_clear_d = (in_item_i.operation == OP_CLEAR);
              now_d      = now_in;
              tid_d      = in_item_i.timer_id;
              proc_d     = '0;
              w_d        = '0;
              n_d        = '0;
              if (used_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        if (adv) begin
          if (is_clear_q) begin
            if (ent.ident == tid_q) begin
              mem_we        = 1'b1;
              mem_waddr     = proc_q[IDX_W-1:0];
              wr_ent.active = 1'b0;
              state_d       = ST_IDLE;
            end else if (more) begin
              mem_re    = 1'b1;
              mem_raddr = proc_inc[IDX_W-1:0];
              proc_d    = proc_inc;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            if (fire) begin
              n_d = n_q + N_W'(1);
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_d = '{result_kind: KIND_FIRED, result_id: pend_id_q,
                          last_of_run: 1'b0};
              end
              pend_valid_d = 1'b1;
              pend_id_d    = ent.ident;
            end
            if (keep) begin
              mem_we        = 1'b1;
              mem_waddr     = w_q[IDX_W-1:0];
              wr_ent.active = 1'b1;
              if (fire) begin
                wr_ent.due = sat_add(now_q, ent.period);
              end
              w_d = w_inc;
            end
            if (more) begin
              mem_re    = 1'b1;
              mem_raddr = proc_inc[IDX_W-1:0];
              proc_d    = proc_inc;
            end else begin
              used_d  = keep ? w_inc : w_q;
              state_d = (pend_valid_q || fire) ? ST_FLUSH : ST_IDLE;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d = '{result_kind: KIND_FIRED, result_id: pend_id_q, last_of_run: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    mem_wdata = wr_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      next_id_q    <= ID_W'(1);
      is_clear_q   <= 1'b0;
      proc_q       <= '0;
      w_q          <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      next_id_q    <= next_id_d;
      is_clear_q   <= is_clear_d;
      proc_q       <= proc_d;
      w_q          <= w_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    tid_q     <= tid_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TIMER_SLOTS))
    else $error("slot count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (w_q <= proc_q))
    else $error("compaction write overtook the read walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_valid_q)
    else $error("flush without a pending fired item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("id counter reached zero");

endmodule

/* rtl/mtt_mem.sv */
`timescale 1ns / 1ps

module mtt_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 111,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
